### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the button click sequence detector.
// Depends on nothing; each file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed: invariant");

// The consequent holds at the edge where the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent holds at the edge after the one where the antecedent holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/bcsd_pkg.sv
// Package of the button click sequence detector: widths, register indexes,
// reset values and gesture codes. Depends on nothing.
package bcsd_pkg;

	localparam int unsigned TICK_W    = 16;
	localparam int unsigned GESTURE_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_TIMEOUT  = CFG_IDX_W'(1);

	localparam logic [TICK_W-1:0] SHORT_PRESS_LIMIT_RST = TICK_W'(300);
	localparam logic [TICK_W-1:0] SEQUENCE_TIMEOUT_RST  = TICK_W'(400);
	localparam logic [TICK_W-1:0] TICK_MAX              = '1;

	localparam logic [GESTURE_W-1:0] GESTURE_SINGLE      = GESTURE_W'(0);
	localparam logic [GESTURE_W-1:0] GESTURE_LONG        = GESTURE_W'(1);
	localparam logic [GESTURE_W-1:0] GESTURE_DOUBLE      = GESTURE_W'(2);
	localparam logic [GESTURE_W-1:0] GESTURE_SHORT_LONG  = GESTURE_W'(3);
	localparam logic [GESTURE_W-1:0] GESTURE_LONG_SHORT  = GESTURE_W'(4);
	localparam logic [GESTURE_W-1:0] GESTURE_DOUBLE_LONG = GESTURE_W'(5);

endpackage

### rtl/core/bcsd_level_if.sv
// Channel carrying one sampled button level per request.
// Depends on nothing.
interface bcsd_level_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink (input valid, input button_level, output ready);
endinterface

### rtl/core/bcsd_gesture_if.sv
// Channel carrying one gesture code per request.
// Depends on bcsd_pkg for the code width.
interface bcsd_gesture_if;
	logic                              valid;
	logic                              ready;
	logic [bcsd_pkg::GESTURE_W-1:0]    gesture_code;

	modport source (output valid, output gesture_code, input ready);
	modport sink (input valid, input gesture_code, output ready);
endinterface

### rtl/core/bcsd_cfg_if.sv
// Configuration write channel: register index and write data per request.
// Depends on bcsd_pkg for the field widths.
interface bcsd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bcsd_pkg::CFG_IDX_W-1:0]    index;
	logic [bcsd_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/button_click_sequence_detector.sv
// Channel      Dir  Payload            Width
// button_ch    in   button_level       1
// gesture_ch   out  gesture_code       3
// cfg          in   index, data        2, 16
//
// One button request is taken per cycle unless stalled; the result register offers gestures.
// The input register feeds one pass of compare and count logic into the result register.
// When the result register is full and stalled, the input register holds and then stalls.
// Reset clears the state, the registers to their default values and all valid flags.
// Configuration writes are taken in every cycle.
//
// Top level of the button click sequence detector.
// Depends on bcsd_pkg, the three channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module button_click_sequence_detector (
	input logic             clk,
	input logic             arst_n,
	bcsd_level_if.sink      button_ch,
	bcsd_gesture_if.source  gesture_ch,
	bcsd_cfg_if.sink        cfg
);
	import bcsd_pkg::*;

	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_SHORT_FIRST,
		PHASE_LONG_FIRST
	} phase_t;

	logic                 valid_s1;
	logic                 level_s1;
	logic                 advance;

	logic [TICK_W-1:0]    short_limit_q;
	logic [TICK_W-1:0]    seq_timeout_q;

	phase_t               phase_q, phase_d;
	logic                 prior_q;
	logic [TICK_W-1:0]    press_q, press_d;
	logic [TICK_W-1:0]    left_q, left_d;
	logic                 out_valid_q;
	logic [GESTURE_W-1:0] out_code_q;

	logic                 emit_d;
	logic [GESTURE_W-1:0] code_d;
	logic [TICK_W-1:0]    press_inc;
	logic                 is_short;
	logic                 falling;
	logic                 rising;

	assign advance         = valid_s1 && (!out_valid_q || gesture_ch.ready);
	assign button_ch.ready = !valid_s1 || advance;
	assign cfg.ready       = 1'b1;

	assign gesture_ch.valid        = out_valid_q;
	assign gesture_ch.gesture_code = out_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (button_ch.ready) begin
			valid_s1 <= button_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (button_ch.valid && button_ch.ready) begin
			level_s1 <= button_ch.button_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_limit_q <= SHORT_PRESS_LIMIT_RST;
			seq_timeout_q <= SEQUENCE_TIMEOUT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_SHORT_PRESS_LIMIT) begin
				short_limit_q <= cfg.data;
			end else if (cfg.index == CFG_SEQUENCE_TIMEOUT) begin
				seq_timeout_q <= cfg.data;
			end
		end
	end

	assign press_inc = (prior_q && press_q != TICK_MAX) ? press_q + 1'b1 : press_q;
	assign is_short  = press_inc <= short_limit_q;
	assign falling   = prior_q && !level_s1;
	assign rising    = !prior_q && level_s1;

	always_comb begin
		phase_d = phase_q;
		press_d = rising ? '0 : press_inc;
		left_d  = left_q;
		emit_d  = 1'b0;
		code_d  = GESTURE_SINGLE;
		if (falling) begin
			unique case (phase_q)
				PHASE_SHORT_FIRST: begin
					emit_d  = 1'b1;
					code_d  = is_short ? GESTURE_DOUBLE : GESTURE_SHORT_LONG;
					phase_d = PHASE_IDLE;
					left_d  = '0;
				end
				PHASE_LONG_FIRST: begin
					emit_d  = 1'b1;
					code_d  = is_short ? GESTURE_LONG_SHORT : GESTURE_DOUBLE_LONG;
					phase_d = PHASE_IDLE;
					left_d  = '0;
				end
				default: begin
					phase_d = is_short ? PHASE_SHORT_FIRST : PHASE_LONG_FIRST;
					left_d  = (seq_timeout_q == '0) ? TICK_W'(1) : seq_timeout_q;
				end
			endcase
		end else if (left_q != '0) begin
			left_d = left_q - 1'b1;
			if (left_q == TICK_W'(1)) begin
				phase_d = PHASE_IDLE;
				emit_d  = (phase_q == PHASE_SHORT_FIRST) || (phase_q == PHASE_LONG_FIRST);
				code_d  = (phase_q == PHASE_LONG_FIRST) ? GESTURE_LONG : GESTURE_SINGLE;
			end
		end else if (phase_q != PHASE_SHORT_FIRST && phase_q != PHASE_LONG_FIRST) begin
			phase_d = PHASE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PHASE_IDLE;
			prior_q     <= 1'b0;
			press_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= GESTURE_SINGLE;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				prior_q <= level_s1;
				press_q <= press_d;
				left_q  <= left_d;
			end
			if (advance && emit_d) begin
				out_valid_q <= 1'b1;
				out_code_q  <= code_d;
			end else if (gesture_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_HOLDS(a_timeout_with_phase, clk, arst_n, (phase_q == PHASE_IDLE) == (left_q == '0))
	`ASSERT_NEXT(a_emit_fills_output, clk, arst_n, advance && emit_d, out_valid_q)
	`ASSERT_IMPLIES(a_code_in_range, clk, arst_n, out_valid_q, out_code_q <= GESTURE_DOUBLE_LONG)
	`ASSERT_NEXT(a_press_monotonic, clk, arst_n, advance && !rising, press_q >= $past(press_q))

endmodule
